// File: design/aegis128l_state_update_defines.svh
// assertion macros for the aegis-128l state update block
`ifndef AEGIS128L_STATE_UPDATE_DEFINES_SVH
`define AEGIS128L_STATE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define A128_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define A128_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define A128_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define A128_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/a128_pkg.sv
// types, constants and aes round functions for the aegis-128l state update
`default_nettype none
package a128_pkg;
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [127:0] t_block;
    typedef logic [63:0]  t_half;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] word_index;
        t_half      d1_low;
        t_half      d1_high;
        t_half      d2_low;
        t_half      d2_high;
    } t_in_item;

    typedef struct packed {
        t_half read_data;
    } t_out_item;

    // per-cell control from the top level
    typedef struct packed {
        logic       load;
        logic       update;
        logic       high;
        t_half      load_data;
    } t_cell_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes encryption round; byte k sits at bits 8k+7:8k
    function automatic t_block aes_round(input t_block din, input t_block key);
        logic [7:0] t [16];
        t_block     res;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = SBOX[din[8 * (r + 4 * ((c + r) % 4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            res[32 * c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            res[32 * c + 8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            res[32 * c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            res[32 * c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        aes_round = res ^ key;
    endfunction
endpackage
`default_nettype wire

// File: design/a128_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface a128_in_if;
    import a128_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface a128_out_if;
    import a128_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/a128_cell.sv
// one state block cell: holds 128 bits, takes its round input from the previous cell
`default_nettype none
module a128_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire a128_pkg::t_cell_ctrl i_ctrl,
    input  wire a128_pkg::t_block   i_prev,
    input  wire a128_pkg::t_block   i_mix,
    output logic [127:0]            o_block
);
    import a128_pkg::*;
    t_block r_block;
    t_block n_block;

    always_comb begin
        n_block = r_block;
        if (i_ctrl.update) begin
            n_block = aes_round(i_prev, r_block) ^ i_mix;
        end else if (i_ctrl.load) begin
            if (i_ctrl.high) n_block[127:64] = i_ctrl.load_data;
            else             n_block[63:0]   = i_ctrl.load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_block <= '0;
        else          r_block <= n_block;
    end

    assign o_block = r_block;
endmodule
`default_nettype wire

// File: design/aegis128l_state_update.sv
// top level: ring of eight aegis-128l state cells with item handshake
`default_nettype none
`include "aegis128l_state_update_defines.svh"
// Each accepted item is one operation: a load writes one 64-bit half, an update
// runs eight aes rounds at once (one per cell, each fed by its ring neighbor)
// and a read returns a half. One item is accepted per cycle while the output
// register is empty or being emptied; the result sits in that register until
// taken, and no item is taken while a stalled result waits. The state clears
// at reset. read_data is zero for load, update and unused op codes.
module aegis128l_state_update (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    a128_in_if.sink   i_in,
    a128_out_if.source o_out
);
    import a128_pkg::*;

    logic        accept;
    logic        r_out_valid;
    t_half       r_read_data;
    t_half       n_read_data;
    t_block      blocks [8];
    t_cell_ctrl  ctrl [8];
    t_block      mix [8];

    // ready whenever the output register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    for (genvar b = 0; b < 8; b++) begin : g_cell
        always_comb begin
            ctrl[b].update    = accept && (i_in.data.op == OP_UPDATE);
            ctrl[b].load      = accept && (i_in.data.op == OP_LOAD)
                                && (i_in.data.word_index[3:1] == 3'(b));
            ctrl[b].high      = i_in.data.word_index[0];
            ctrl[b].load_data = i_in.data.d1_low;
            // message words enter at cells zero and four
            if (b == 0)      mix[b] = {i_in.data.d1_high, i_in.data.d1_low};
            else if (b == 4) mix[b] = {i_in.data.d2_high, i_in.data.d2_low};
            else             mix[b] = '0;
        end
        a128_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl[b]),
            .i_prev  (blocks[(b + 7) % 8]),
            .i_mix   (mix[b]),
            .o_block (blocks[b])
        );
    end

    // read mux over the sixteen halves
    always_comb begin
        n_read_data = '0;
        if (i_in.data.op == OP_READ) begin
            n_read_data = i_in.data.word_index[0] ? blocks[i_in.data.word_index[3:1]][127:64]
                                                  : blocks[i_in.data.word_index[3:1]][63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_read_data <= n_read_data;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data.read_data = r_read_data;

    // every accepted item produces a result in the next cycle
    `A128_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, accept, r_out_valid)
    // a stalled result is never overwritten
    `A128_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_out_valid && !o_out.ready, !i_in.ready)
    // non-read items carry zero data
    `A128_ASSERT_NXT(a_zero_nonread, i_clk, i_rst_n,
        accept && (i_in.data.op != OP_READ), r_read_data == '0)
endmodule
`default_nettype wire

// File: tb/aegis128l_state_update_checker.sv
// checker: watches both channels, predicts aegis-128l state results and compares
`timescale 1ns / 1ps
module aegis128l_state_update_checker
    import a128_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  t_in_item  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);
    t_half     halves [16];
    t_half     read_queue [$];
    logic [7:0] sub_table [256];

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        gmul2 = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = gmul2(a);
        end
        gmul = r;
    endfunction

    // sbox built from the field inverse and the affine map
    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] r, p;
        r = 8'h01;
        p = x;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) r = gmul(r, p);
            p = gmul(p, p);
        end
        if (x == 0) r = 0;
        sub_byte = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
                   ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    function automatic t_block enc_round(input t_block s, input t_block k);
        logic [7:0] t [16];
        t_block o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4 * c] = sub_table[s[8 * (r + 4 * ((c + r) % 4)) +: 8]];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            o[32*c +: 8]    = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
            o[32*c+8 +: 8]  = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
            o[32*c+16 +: 8] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
            o[32*c+24 +: 8] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
        end
        enc_round = o ^ k;
    endfunction

    task automatic apply_item(input t_in_item it);
        t_block nxt [8];
        t_half rd;
        rd = 0;
        case (it.op)
            OP_LOAD: halves[it.word_index] = it.d1_low;
            OP_UPDATE: begin
                for (int b = 0; b < 8; b++)
                    nxt[b] = enc_round({halves[2*((b+7)%8)+1], halves[2*((b+7)%8)]},
                                       {halves[2*b+1], halves[2*b]});
                nxt[0] ^= {it.d1_high, it.d1_low};
                nxt[4] ^= {it.d2_high, it.d2_low};
                for (int b = 0; b < 8; b++) begin
                    halves[2*b]   = nxt[b][63:0];
                    halves[2*b+1] = nxt[b][127:64];
                end
            end
            OP_READ: rd = halves[it.word_index];
            default: ;
        endcase
        read_queue.push_back(rd);
    endtask

    initial begin
        o_fail_count = 0;
        for (int i = 0; i < 256; i++) sub_table[i] = sub_byte(i[7:0]);
        for (int i = 0; i < 16; i++) halves[i] = 0;
    end

    assign o_pending = read_queue.size();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (read_queue.size() == 0) begin
                    $error("unexpected result read_data %h", i_out_data.read_data);
                    o_fail_count++;
                end else if (read_queue[0] !== i_out_data.read_data) begin
                    $error("read_data expected %h actual %h", read_queue[0],
                           i_out_data.read_data);
                    o_fail_count++;
                    void'(read_queue.pop_front());
                end else begin
                    void'(read_queue.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) apply_item(i_in_data);
        end
    end
endmodule

// File: tb/testbench.sv
// testbench top: drives items into the aegis-128l state update and gives the verdict
`timescale 1ns / 1ps
module testbench;
    import a128_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count;
    int   pending;
    int   gap_left = 0;
    int   stall_left = 0;
    bit   calm = 0;
    bit   stim_done = 0;

    a128_in_if  in_ch();
    a128_out_if out_ch();

    aegis128l_state_update i_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));

    aegis128l_state_update_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_out_data(out_ch.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    function automatic t_half rand_half();
        case ($urandom_range(0, 5))
            0: rand_half = '0;
            1: rand_half = '1;
            default: rand_half = {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] op, input logic [3:0] idx);
        t_in_item it;
        it.op = op;
        it.word_index = idx;
        it.d1_low = rand_half();
        it.d1_high = rand_half();
        it.d2_low = rand_half();
        it.d2_high = rand_half();
        make_item = it;
    endfunction

    // hold one item on the channel until accepted, with random gaps before it
    task automatic send_item(input t_in_item it);
        if (!calm && gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 18);
        while (gap_left > 0) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
            gap_left--;
        end
        in_ch.valid <= 1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // result side: random stall bursts, none once things go calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (stall_left > 0 && !calm) begin
            out_ch.ready <= 0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_ch.ready <= 0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            out_ch.ready <= 1;
        end
    end

    initial begin
        t_in_item it;
        int wait_cycles;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: reads of cleared state, extreme loads, updates, unused op
        send_item(make_item(OP_READ, 4'd0));
        send_item(make_item(OP_READ, 4'd15));
        for (int i = 0; i < 16; i++) begin
            it = make_item(OP_LOAD, i[3:0]);
            it.d1_low = (i % 2) ? '1 : 64'h0123_4567_89ab_cdef ^ i;
            send_item(it);
        end
        it = make_item(OP_UPDATE, 4'd9);
        it.d1_low = '1; it.d1_high = '1; it.d2_low = '1; it.d2_high = '1;
        send_item(it);
        it.d1_low = 0; it.d1_high = 0; it.d2_low = 0; it.d2_high = 0;
        send_item(it);
        send_item(make_item(OP_UNUSED, 4'd5));
        send_item(make_item(OP_READ, 4'd0));
        send_item(make_item(OP_READ, 4'd15));
        send_item(make_item(OP_READ, 4'd8));
        // random: mostly loads and updates interleaved with reads
        for (int n = 0; n < 2000; n++) begin
            if (n > 1700) calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: it = make_item(OP_LOAD, 4'($urandom_range(0, 15)));
                3, 4, 5: it = make_item(OP_UPDATE, 4'($urandom_range(0, 15)));
                9:       it = make_item(OP_UNUSED, 4'($urandom_range(0, 15)));
                default: it = make_item(OP_READ, 4'($urandom_range(0, 15)));
            endcase
            send_item(it);
        end
        in_ch.valid <= 0;
        stim_done = 1;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("aegis128l_state_update regression: pass");
        else
            $display("aegis128l_state_update regression: fail");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("aegis128l_state_update regression: fail");
        $finish;
    end
endmodule
